// ===== rtl/cst_pkg.sv =====
// Shared types and command codes for the copy-on-write sector tracker.
package cst_pkg;

	localparam int MASK_W   = 32;
	localparam int CMD_W    = 2;
	localparam int OFFSET_W = 20;
	localparam int BYTE_W   = 21;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_LOAD   = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	// Outcome of one pass through the merge unit.
	typedef struct packed {
		logic [MASK_W-1:0] read_mask;
		logic [MASK_W-1:0] new_lo;
		logic [MASK_W-1:0] new_hi;
		logic              changed;
	} merge_res_t;

endpackage

// ===== rtl/cst_ram.sv =====
// Generic single-port RAM with registered read data.
module cst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/cst_merge_unit.sv =====
// Shift-and-merge unit: aligns the run mask over a bitmap word pair.
module cst_merge_unit
	import cst_pkg::*;
(
	input  logic [MASK_W-1:0] word_lo,
	input  logic [MASK_W-1:0] word_hi,
	input  logic [4:0]        bit_ofs,
	input  logic [MASK_W-1:0] run_mask,
	output merge_res_t        res
);

	logic [2*MASK_W-1:0] old_pair;
	logic [2*MASK_W-1:0] run_pair;
	logic [2*MASK_W-1:0] read_pair;

	always_comb begin
		old_pair  = {word_hi, word_lo};
		run_pair  = {{MASK_W{1'b0}}, run_mask} << bit_ofs;
		read_pair = old_pair >> bit_ofs;

		res.read_mask = read_pair[MASK_W-1:0] & run_mask;
		res.new_lo    = word_lo | run_pair[MASK_W-1:0];
		res.new_hi    = word_hi | run_pair[2*MASK_W-1:MASK_W];
		res.changed   = |(run_pair & ~old_pair);
	end

endmodule

// ===== rtl/cow_sector_bitmap_tracker.sv =====
// Copy-on-write sector tracker: bitmap RAM, sequencer and result registers.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-----------------------------------------------
//  request   | start / busy        | command, start_sector, sector_count,
//            |                     | load_word_index, load_word_data
//  result    | done (1-cycle)      | served_mask, bitmap_changed, cow_byte_offset,
//            |                     | bitmap_word_low, bitmap_word_high, run_too_long
//  config    | cfg_valid/cfg_ready | cfg_data (bitmap file offset)
//
// A read request passes the steps RD_LO, RD_HI, MERGE and FINISH, a write adds WR_LO
// and WR_HI after MERGE, a load goes through LOAD to FINISH, and an over-long run or the
// unused command code goes straight to FINISH; busy drops in the done cycle. The single
// RAM port sets this: each word of the pair is read, then written back, one access a cycle.
// After reset a clearing pass zeroes the bitmap with busy high; config writes
// are taken at any time.
// The result is shown for one cycle under done; the receiver cannot stall it.
// TRACKED_SECTORS must be a power of two.
module cow_sector_bitmap_tracker
	import cst_pkg::*;
#(
	parameter int TRACKED_SECTORS = 65536,
	parameter int MAX_RUN_SECTORS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [CMD_W-1:0]    command,
	input  logic [15:0]         start_sector,
	input  logic [5:0]          sector_count,
	input  logic [10:0]         load_word_index,
	input  logic [MASK_W-1:0]   load_word_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [OFFSET_W-1:0] cfg_data,
	output logic                done,
	output logic [MASK_W-1:0]   served_mask,
	output logic                bitmap_changed,
	output logic [BYTE_W-1:0]   cow_byte_offset,
	output logic [MASK_W-1:0]   bitmap_word_low,
	output logic [MASK_W-1:0]   bitmap_word_high,
	output logic                run_too_long
);

	localparam int SECT_W        = $clog2(TRACKED_SECTORS);
	localparam int MAP_DEPTH     = TRACKED_SECTORS / 32;
	localparam int AW            = $clog2(MAP_DEPTH);
	localparam logic [AW-1:0] LAST_WORD = AW'(MAP_DEPTH - 1);
	localparam logic [5:0]    MAX_RUN   = 6'(MAX_RUN_SECTORS);

	typedef enum logic [8:0] {
		ST_CLEAR  = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_RD_LO  = 9'b000000100,
		ST_RD_HI  = 9'b000001000,
		ST_MERGE  = 9'b000010000,
		ST_WR_LO  = 9'b000100000,
		ST_WR_HI  = 9'b001000000,
		ST_LOAD   = 9'b010000000,
		ST_FINISH = 9'b100000000
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        clr_q;
	logic [OFFSET_W-1:0]  file_ofs_q;
	cmd_t                 cmd_q;
	logic                 too_long_q;
	logic [AW-1:0]        word_q;
	logic [4:0]           bit_q;
	logic [MASK_W-1:0]    run_mask_q;
	logic [AW-1:0]        load_idx_q;
	logic [MASK_W-1:0]    load_data_q;
	logic [MASK_W-1:0]    lo_q;
	merge_res_t           res_q;

	logic                 done_q;
	logic [MASK_W-1:0]    mask_q;
	logic                 changed_q;
	logic [BYTE_W-1:0]    byte_ofs_q;
	logic [MASK_W-1:0]    word_lo_q;
	logic [MASK_W-1:0]    word_hi_q;
	logic                 run_long_q;

	logic                 accept;
	cmd_t                 cmd_in;
	logic                 is_rw_in;
	logic                 too_long_in;
	logic [SECT_W-1:0]    sec_wrapped;
	logic [32:0]          run_wide;
	logic [AW-1:0]        next_word;
	logic                 report_change;

	logic                 ram_we;
	logic [AW-1:0]        ram_addr;
	logic [MASK_W-1:0]    ram_wdata;
	logic [MASK_W-1:0]    ram_rdata;
	merge_res_t           merge_res;

	function automatic logic is_rw_cmd(input cmd_t c);
		return (c == CMD_READ) || (c == CMD_WRITE);
	endfunction

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign cmd_in      = cmd_t'(command);
	assign is_rw_in    = (cmd_in == CMD_READ) || (cmd_in == CMD_WRITE);
	assign too_long_in = is_rw_in && (sector_count > MAX_RUN);
	assign sec_wrapped = SECT_W'(start_sector);
	assign run_wide    = (33'd1 << sector_count) - 33'd1;
	assign next_word   = word_q + AW'(1);

	assign report_change = (cmd_q == CMD_WRITE) && !too_long_q && res_q.changed;

	cst_ram #(
		.WIDTH(MASK_W),
		.DEPTH(MAP_DEPTH)
	) u_bitmap_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	cst_merge_unit u_merge (
		.word_lo (lo_q),
		.word_hi (ram_rdata),
		.bit_ofs (bit_q),
		.run_mask(run_mask_q),
		.res     (merge_res)
	);

	// RAM port steering per sequencer step
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = word_q;
		ram_wdata = res_q.new_lo;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			ST_RD_HI: begin
				ram_addr = next_word;
			end
			ST_WR_LO: begin
				ram_we = 1'b1;
			end
			ST_WR_HI: begin
				ram_we    = 1'b1;
				ram_addr  = next_word;
				ram_wdata = res_q.new_hi;
			end
			ST_LOAD: begin
				ram_we    = 1'b1;
				ram_addr  = load_idx_q;
				ram_wdata = load_data_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			file_ofs_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				file_ofs_q <= cfg_data;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (cmd_in == CMD_LOAD) begin
							state_q <= ST_LOAD;
						end else if (!is_rw_in || too_long_in) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_RD_LO;
						end
					end
				end
				ST_RD_LO: state_q <= ST_RD_HI;
				ST_RD_HI: state_q <= ST_MERGE;
				ST_MERGE: begin
					state_q <= (cmd_q == CMD_WRITE) ? ST_WR_LO : ST_FINISH;
				end
				ST_WR_LO: state_q <= ST_WR_HI;
				ST_WR_HI: state_q <= ST_FINISH;
				ST_LOAD:  state_q <= ST_FINISH;
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request capture and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= cmd_in;
			too_long_q  <= too_long_in;
			word_q      <= sec_wrapped[SECT_W-1:5];
			bit_q       <= sec_wrapped[4:0];
			run_mask_q  <= run_wide[MASK_W-1:0];
			load_idx_q  <= AW'(load_word_index);
			load_data_q <= load_word_data;
		end
		if (state_q == ST_RD_HI) begin
			lo_q <= ram_rdata;
		end
		if (state_q == ST_MERGE) begin
			res_q <= merge_res;
		end
		if (state_q == ST_FINISH) begin
			run_long_q <= too_long_q;
			// a write covers the whole run, a read shows only copied sectors
			mask_q     <= (!is_rw_cmd(cmd_q) || too_long_q) ? '0
				: (cmd_q == CMD_WRITE) ? run_mask_q : res_q.read_mask;
			changed_q  <= report_change;
			byte_ofs_q <= report_change
				? BYTE_W'({word_q, 2'b00}) + BYTE_W'(file_ofs_q) : '0;
			word_lo_q  <= report_change ? res_q.new_lo : '0;
			word_hi_q  <= report_change ? res_q.new_hi : '0;
		end
	end

	assign done             = done_q;
	assign served_mask      = mask_q;
	assign bitmap_changed   = changed_q;
	assign cow_byte_offset  = byte_ofs_q;
	assign bitmap_word_low  = word_lo_q;
	assign bitmap_word_high = word_hi_q;
	assign run_too_long     = run_long_q;

	// An accepted request always holds busy for at least the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy dropped right after a request was accepted");

	// A result pulse lasts one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// A rejected run reports nothing else.
	a_too_long_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && run_too_long) |-> (served_mask == '0 && !bitmap_changed))
		else $error("over-long run reported mask or change");

	// Without a change the pair fields stay zero.
	a_unchanged_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !bitmap_changed) |->
			(cow_byte_offset == '0 && bitmap_word_low == '0 && bitmap_word_high == '0))
		else $error("pair fields set without a bitmap change");

	// The result follows the finishing step of the sequencer.
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |=> (done && state_q == ST_IDLE))
		else $error("finish step did not raise done");

endmodule

// ===== sim/cow_sector_bitmap_tracker_tb.sv =====
// Self-checking testbench for the copy-on-write sector bitmap tracker.
module cow_sector_bitmap_tracker_tb
	import cst_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_RUN      = 32;
	localparam int MAP_WORDS    = 2048;
	localparam int PHASE_ITEMS  = 340;
	localparam int PHASES       = 5;
	localparam int STALL_LIMIT  = 10000;
	localparam int PRINT_LIMIT  = 40;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] sector;
		logic [5:0]  count;
		logic [10:0] idx;
		logic [31:0] data;
	} request_t;

	typedef struct packed {
		logic [31:0] mask;
		logic        changed;
		logic [20:0] byte_offset;
		logic [31:0] word_low;
		logic [31:0] word_high;
		logic        too_long;
	} tracker_result_t;

	typedef struct packed {
		request_t        req;
		logic            typed;
		tracker_result_t want;
	} dir_row_t;

	localparam tracker_result_t NO_RESULT = '0;
	localparam tracker_result_t TOO_LONG  = '{too_long: 1'b1, default: '0};

	logic                clk;
	logic                arst_n          = 1'b0;
	logic                start           = 1'b0;
	logic                busy;
	logic [CMD_W-1:0]    command         = '0;
	logic [15:0]         start_sector    = '0;
	logic [5:0]          sector_count    = '0;
	logic [10:0]         load_word_index = '0;
	logic [MASK_W-1:0]   load_word_data  = '0;
	logic                cfg_valid       = 1'b0;
	logic                cfg_ready;
	logic [OFFSET_W-1:0] cfg_data        = '0;
	logic                done;
	logic [MASK_W-1:0]   served_mask;
	logic                bitmap_changed;
	logic [BYTE_W-1:0]   cow_byte_offset;
	logic [MASK_W-1:0]   bitmap_word_low;
	logic [MASK_W-1:0]   bitmap_word_high;
	logic                run_too_long;

	logic [31:0]     copied_map [MAP_WORDS] = '{default: '0};
	logic [19:0]     map_offset = '0;
	tracker_result_t pending_results [$];
	int              mismatch_count = 0;
	int              idle_cycles = 0;
	int              burst_left = 0;

	cow_sector_bitmap_tracker uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.command          (command),
		.start_sector     (start_sector),
		.sector_count     (sector_count),
		.load_word_index  (load_word_index),
		.load_word_data   (load_word_data),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.done             (done),
		.served_mask      (served_mask),
		.bitmap_changed   (bitmap_changed),
		.cow_byte_offset  (cow_byte_offset),
		.bitmap_word_low  (bitmap_word_low),
		.bitmap_word_high (bitmap_word_high),
		.run_too_long     (run_too_long)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Apply one request to the copied-sector map and return its result.
	function automatic tracker_result_t track_request(request_t r);
		tracker_result_t res;
		logic [15:0]     s;
		logic [10:0]     w;
		res = '0;
		case (r.cmd)
			CMD_LOAD: begin
				copied_map[r.idx] = r.data;
			end
			CMD_READ, CMD_WRITE: begin
				if (r.count > MAX_RUN) begin
					res.too_long = 1'b1;
				end else begin
					for (int i = 0; i < r.count; i++) begin
						s = r.sector + 16'(i);
						if (r.cmd == CMD_READ) begin
							res.mask[i] = copied_map[s[15:5]][s[4:0]];
						end else begin
							res.mask[i] = 1'b1;
							if (!copied_map[s[15:5]][s[4:0]])
								res.changed = 1'b1;
							copied_map[s[15:5]][s[4:0]] = 1'b1;
						end
					end
					if (res.changed) begin
						w = r.sector[15:5];
						res.byte_offset = {w, 2'b00} + 21'(map_offset);
						res.word_low    = copied_map[w];
						res.word_high   = copied_map[w + 11'd1];
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic dir_row_t dir_row(cmd_t c, logic [15:0] s, logic [5:0] n,
			logic [10:0] x, logic [31:0] d, logic typed, tracker_result_t want);
		dir_row_t row;
		row.req   = '{cmd: c, sector: s, count: n, idx: x, data: d};
		row.typed = typed;
		row.want  = want;
		return row;
	endfunction

	// Most requests land near a hot spot so the map fills up and gets reloaded.
	function automatic request_t random_request(logic [15:0] hot);
		request_t    r;
		int unsigned p;
		p = $urandom_range(0, 99);
		r.cmd = p < 40 ? CMD_READ : p < 75 ? CMD_WRITE : p < 93 ? CMD_LOAD : CMD_UNUSED;
		r.sector = ($urandom_range(0, 9) < 7) ? hot + 16'($urandom_range(0, 191))
			: 16'($urandom);
		case ($urandom_range(0, 19))
			0: r.count = 6'd0;
			1: r.count = 6'($urandom_range(33, 63));
			2: r.count = 6'd32;
			default: r.count = 6'($urandom_range(1, 32));
		endcase
		r.idx = ($urandom_range(0, 9) < 7) ? hot[15:5] + 11'($urandom_range(0, 6))
			: 11'($urandom);
		case ($urandom_range(0, 7))
			0: r.data = 32'h0;
			1: r.data = 32'hFFFF_FFFF;
			default: r.data = $urandom;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int unsigned p;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		p = $urandom_range(0, 99);
		if (p < 5) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (p < 50)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t ns: %s mismatch: got %h, want %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Call at a rising edge; returns at the edge that accepts the request.
	task automatic send_request(request_t r, logic typed, tracker_result_t want);
		int              gap;
		tracker_result_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		command         <= r.cmd;
		start_sector    <= r.sector;
		sector_count    <= r.count;
		load_word_index <= r.idx;
		load_word_data  <= r.data;
		start           <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = track_request(r);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic write_offset(logic [19:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid  <= 1'b0;
		map_offset = value;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		tracker_result_t got;
		tracker_result_t want;
		if (arst_n && done) begin
			got = '{mask: served_mask, changed: bitmap_changed, byte_offset: cow_byte_offset,
				word_low: bitmap_word_low, word_high: bitmap_word_high,
				too_long: run_too_long};
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", got.mask, '0);
			end else begin
				want = pending_results.pop_front();
				if (got.mask !== want.mask)
					report_mismatch("served_mask", got.mask, want.mask);
				if (got.changed !== want.changed)
					report_mismatch("bitmap_changed", 32'(got.changed), 32'(want.changed));
				if (got.byte_offset !== want.byte_offset)
					report_mismatch("cow_byte_offset", 32'(got.byte_offset),
						32'(want.byte_offset));
				if (got.word_low !== want.word_low)
					report_mismatch("bitmap_word_low", got.word_low, want.word_low);
				if (got.word_high !== want.word_high)
					report_mismatch("bitmap_word_high", got.word_high, want.word_high);
				if (got.too_long !== want.too_long)
					report_mismatch("run_too_long", 32'(got.too_long), 32'(want.too_long));
			end
		end
	end

	// Count cycles with no request, result or register write; covers the clearing pass.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		dir_row_t    rows [$];
		logic [15:0] hot;
		logic [19:0] offs;

		rows.push_back(dir_row(CMD_READ, 16'd0, 6'd32, 11'd0, 32'h0, 1'b1, NO_RESULT));
		rows.push_back(dir_row(CMD_WRITE, 16'd0, 6'd32, 11'd0, 32'h0, 1'b1,
			'{mask: 32'hFFFF_FFFF, changed: 1'b1, word_low: 32'hFFFF_FFFF, default: '0}));
		rows.push_back(dir_row(CMD_READ, 16'd0, 6'd32, 11'd0, 32'h0, 1'b1,
			'{mask: 32'hFFFF_FFFF, default: '0}));
		// same run again: nothing new, so no change report
		rows.push_back(dir_row(CMD_WRITE, 16'd0, 6'd32, 11'd0, 32'h0, 1'b1,
			'{mask: 32'hFFFF_FFFF, default: '0}));
		rows.push_back(dir_row(CMD_READ, 16'd0, 6'd33, 11'd0, 32'h0, 1'b1, TOO_LONG));
		rows.push_back(dir_row(CMD_WRITE, 16'd100, 6'd63, 11'd0, 32'h0, 1'b1, TOO_LONG));
		rows.push_back(dir_row(CMD_WRITE, 16'd40, 6'd0, 11'd0, 32'h0, 1'b1, NO_RESULT));
		rows.push_back(dir_row(CMD_READ, 16'd40, 6'd0, 11'd0, 32'h0, 1'b1, NO_RESULT));
		rows.push_back(dir_row(CMD_LOAD, 16'd0, 6'd0, 11'd2047, 32'hFFFF_FFFF, 1'b1,
			NO_RESULT));
		rows.push_back(dir_row(CMD_READ, 16'd65504, 6'd32, 11'd0, 32'h0, 1'b1,
			'{mask: 32'hFFFF_FFFF, default: '0}));
		rows.push_back(dir_row(CMD_LOAD, 16'd0, 6'd0, 11'd0, 32'h0, 1'b1, NO_RESULT));
		// run wraps from the last sector into word zero
		rows.push_back(dir_row(CMD_WRITE, 16'd65535, 6'd2, 11'd0, 32'h0, 1'b1,
			'{mask: 32'h3, changed: 1'b1, byte_offset: 21'd8188, word_low: 32'hFFFF_FFFF,
			word_high: 32'h1, default: '0}));
		rows.push_back(dir_row(CMD_LOAD, 16'd0, 6'd0, 11'd2047, 32'h0, 1'b1, NO_RESULT));
		rows.push_back(dir_row(CMD_UNUSED, 16'd65535, 6'd63, 11'd2047, 32'hFFFF_FFFF, 1'b1,
			NO_RESULT));
		rows.push_back(dir_row(CMD_LOAD, 16'd0, 6'd0, 11'd5, 32'hA5A5_5A5A, 1'b0, NO_RESULT));
		rows.push_back(dir_row(CMD_READ, 16'd160, 6'd32, 11'd0, 32'h0, 1'b0, NO_RESULT));
		rows.push_back(dir_row(CMD_WRITE, 16'd170, 6'd20, 11'd0, 32'h0, 1'b0, NO_RESULT));
		rows.push_back(dir_row(CMD_READ, 16'd165, 6'd31, 11'd0, 32'h0, 1'b0, NO_RESULT));
		rows.push_back(dir_row(CMD_WRITE, 16'd65530, 6'd32, 11'd0, 32'h0, 1'b0, NO_RESULT));
		rows.push_back(dir_row(CMD_READ, 16'd65520, 6'd32, 11'd0, 32'h0, 1'b0, NO_RESULT));
		rows.push_back(dir_row(CMD_LOAD, 16'd0, 6'd0, 11'd1024, 32'h8000_0001, 1'b0,
			NO_RESULT));
		rows.push_back(dir_row(CMD_READ, 16'd32767, 6'd3, 11'd0, 32'h0, 1'b0, NO_RESULT));
		rows.push_back(dir_row(CMD_WRITE, 16'd32768, 6'd1, 11'd0, 32'h0, 1'b0, NO_RESULT));
		rows.push_back(dir_row(CMD_READ, 16'd32760, 6'd16, 11'd0, 32'h0, 1'b0, NO_RESULT));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_offset(20'h0);

		foreach (rows[k])
			send_request(rows[k].req, rows[k].typed, rows[k].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			offs = (ph == 0 || ph == PHASES - 1) ? 20'hFFFFF : (ph == 2) ? 20'h0
				: 20'($urandom);
			write_offset(offs);
			// one phase sits at the top of the map to exercise wraparound
			hot = (ph == 1) ? 16'hFFC0 : 16'($urandom);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request(random_request(hot), 1'b0, NO_RESULT);
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
